>>> rtl/core/adl32_pkg.sv
// Shared widths, constants and stage types for the Adler-32 checksum unit.
package adl32_pkg;

    localparam int BYTE_FIELDS = 4;
    localparam int DEF_LANES   = 4;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;
    localparam int WEIGHT_W  = 3;
    localparam int WBYTE_W   = 11;
    localparam int SUM_W     = 10;
    localparam int WSUM_W    = 12;
    localparam int HALF_W    = 16;
    localparam int LSUM_W    = 17;
    localparam int HSUM_W    = 19;
    localparam int CSUM_W    = 32;
    localparam int S_TDATA_W = 40;

    localparam logic [LSUM_W-1:0] ADLER_MOD = 17'h0fff1;
    // 2^16 mod 65521
    localparam logic [3:0]        FOLD_K    = 4'd15;
    localparam logic [HALF_W-1:0] LOW_INIT  = 16'h0001;
    localparam logic [HALF_W-1:0] HIGH_INIT = 16'h0000;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [WBYTE_W-1:0] wdata;
    } lane_res_t;

    typedef struct packed {
        logic              restart;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [WSUM_W-1:0] wsum;
    } merge_t;

endpackage

>>> rtl/core/adl32_lane.sv
// One byte lane: masks the byte by the count and forms its high-sum weight.
module adl32_lane
    import adl32_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [CNT_W-1:0]  count,
    input  logic [BYTE_W-1:0] data_in,
    output lane_res_t         lane_reg
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(LANE_IDX);

    lane_res_t         lane_next;
    logic              active;
    logic [WEIGHT_W-1:0] weight;

    always_comb begin
        active = count > IDX;
        // byte i is added into the high sum (count - i) times
        weight = active ? WEIGHT_W'(count - IDX) : '0;
        lane_next.data  = active ? data_in : '0;
        lane_next.wdata = WBYTE_W'(weight) * WBYTE_W'(data_in);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

endmodule

>>> rtl/core/adl32_merge.sv
// Merge stage: adds the lane bytes and the weighted lane bytes.
module adl32_merge
    import adl32_pkg::*;
#(
    parameter int NLANES = DEF_LANES
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             restart,
    input  logic [CNT_W-1:0] count,
    input  lane_res_t        lane_in [NLANES],
    output merge_t           merge_reg
);

    merge_t merge_next;

    always_comb begin
        merge_next.restart = restart;
        merge_next.count   = count;
        merge_next.sum     = '0;
        merge_next.wsum    = '0;
        for (int i = 0; i < NLANES; i++) begin
            merge_next.sum  = merge_next.sum + SUM_W'(lane_in[i].data);
            merge_next.wsum = merge_next.wsum + WSUM_W'(lane_in[i].wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            merge_reg <= merge_next;
        end
    end

endmodule

>>> rtl/core/adl32_accum.sv
// Running sums and the output register; applies one merged item per cycle while the output is not stalled.
module adl32_accum
    import adl32_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  merge_t            in_item,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CSUM_W-1:0] m_tdata
);

    logic [HALF_W-1:0] low_reg, low_next;
    logic [HALF_W-1:0] high_reg, high_next;
    logic              valid_reg, valid_next;
    logic [CSUM_W-1:0] data_reg;
    logic              fire;

    logic [HALF_W-1:0] low_base, high_base;
    logic [LSUM_W-1:0] low_sum;
    logic [HSUM_W-1:0] k_low;
    logic [HSUM_W-1:0] high_sum;
    logic [LSUM_W-1:0] high_fold;

    assign in_ready = !valid_reg || m_tready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        low_base  = in_item.restart ? LOW_INIT  : low_reg;
        high_base = in_item.restart ? HIGH_INIT : high_reg;

        low_sum = LSUM_W'(low_base) + LSUM_W'(in_item.sum);
        if (low_sum >= ADLER_MOD) begin
            low_sum = low_sum - ADLER_MOD;
        end

        // high gains count copies of the old low plus the weighted bytes
        k_low    = HSUM_W'(in_item.count) * HSUM_W'(low_base);
        high_sum = HSUM_W'(high_base) + k_low + HSUM_W'(in_item.wsum);

        // fold bits above 16 using 2^16 = 15 mod 65521, then one subtract
        high_fold = LSUM_W'(high_sum[HALF_W-1:0])
                  + LSUM_W'(high_sum[HSUM_W-1:HALF_W]) * LSUM_W'(FOLD_K);
        if (high_fold >= ADLER_MOD) begin
            high_fold = high_fold - ADLER_MOD;
        end

        low_next   = fire ? low_sum[HALF_W-1:0]   : low_reg;
        high_next  = fire ? high_fold[HALF_W-1:0] : high_reg;
        valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= LOW_INIT;
            high_reg  <= HIGH_INIT;
            valid_reg <= 1'b0;
        end else begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg <= {high_next, low_next};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> rtl/core/adl32_checksum_unit_top_placeholder.sv
// Count saturation helper: clamps a byte count to the active lane count.
module adl32_clamp
    import adl32_pkg::*;
#(
    parameter int ACT_LANES = DEF_LANES
) (
    input  logic [CNT_W-1:0] count_in,
    output logic [CNT_W-1:0] count_out
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ACT_LANES);

    assign count_out = (count_in > MAX_CNT) ? MAX_CNT : count_in;

endmodule

>>> rtl/core/adler32_checksum_unit.sv
// Top level of the Adler-32 checksum unit: byte lanes, merge stage, running sums.
//
//   channel  | dir | transfer contents
//   ---------+-----+----------------------------------------------------------
//   s_       | in  | tuser[0] restart; tdata byte_count, byte_zero..byte_three
//   m_       | out | tdata checksum = high sum << 16 | low sum
//
// One transfer per cycle in and out while m_tready does not stall; items pass the lane
// register, merge register and output register in that order. The running sums close a
// loop through the accumulate stage, which sets the rate.
// Reset (aresetn low, synchronous) sets low sum to 1, high sum to 0, empties
// the pipeline. A stall on m_tready holds each stage only while the next is full.
module adler32_checksum_unit
    import adl32_pkg::*;
#(
    parameter int LANES = DEF_LANES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] byte_count, [10:3] byte_zero, [18:11] byte_one,
    // [26:19] byte_two, [34:27] byte_three, [39:35] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] restart
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] low sum, [31:16] high sum
    output logic [CSUM_W-1:0]    m_tdata
);

    localparam int ACT_LANES = (LANES < BYTE_FIELDS) ? LANES : BYTE_FIELDS;

    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic             s1_restart_reg;
    logic [CNT_W-1:0] s1_count_reg;
    logic [CNT_W-1:0] count_sat;
    logic             s1_ready, s2_ready, acc_ready;
    logic             s_fire, s2_load;
    lane_res_t        lane_res [ACT_LANES];
    merge_t           merge_res;

    adl32_clamp #(
        .ACT_LANES (ACT_LANES)
    ) u_clamp (
        .count_in  (s_tdata[CNT_W-1:0]),
        .count_out (count_sat)
    );

    assign s2_ready = !s2_valid_reg || acc_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    // refuse transfers while reset is held
    assign s_tready = s1_ready && aresetn;
    assign s_fire   = s_tvalid && s_tready;
    assign s2_load  = s1_valid_reg && s2_ready;

    for (genvar i = 0; i < ACT_LANES; i++) begin : g_lane
        adl32_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .aclk     (aclk),
            .en       (s_fire),
            .count    (count_sat),
            .data_in  (s_tdata[CNT_W + BYTE_W*i +: BYTE_W]),
            .lane_reg (lane_res[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_restart_reg <= s_tuser[0];
            s1_count_reg   <= count_sat;
        end
    end

    adl32_merge #(
        .NLANES (ACT_LANES)
    ) u_merge (
        .aclk      (aclk),
        .en        (s2_load),
        .restart   (s1_restart_reg),
        .count     (s1_count_reg),
        .lane_in   (lane_res),
        .merge_reg (merge_res)
    );

    always_comb begin
        s1_valid_next = s_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (acc_ready ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    adl32_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s2_valid_reg),
        .in_item  (merge_res),
        .in_ready (acc_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the streaming Adler-32 checksum unit.
`timescale 1ns / 100ps

module tb_top;
    import adl32_pkg::*;

    localparam int LANE_LIMIT  = (DEF_LANES < BYTE_FIELDS) ? DEF_LANES : BYTE_FIELDS;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CSUM_W-1:0]    m_tdata;

    // running sums of the checksum predictor
    logic [HALF_W-1:0] run_low  = LOW_INIT;
    logic [HALF_W-1:0] run_high = HIGH_INIT;

    logic [CSUM_W-1:0] checksum_q[$];
    logic [CSUM_W-1:0] want_sum;
    int                mismatches   = 0;
    int                send_idle    = 0;
    int                recv_idle    = 0;
    bit                hold_req     = 1'b0;
    int                hold_left    = 0;
    int                quiet_cycles = 0;

    adler32_checksum_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Fold one item into the running sums and return the checksum after it.
    function automatic logic [CSUM_W-1:0] fold_item(input logic restart,
                                                    input logic [CNT_W-1:0] count,
                                                    input logic [31:0] lanes);
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        lo = 32'(run_low);
        hi = 32'(run_high);
        if (restart) begin
            lo = 32'(LOW_INIT);
            hi = 32'(HIGH_INIT);
        end
        n = (32'(count) > LANE_LIMIT) ? LANE_LIMIT : 32'(count);
        for (int i = 0; i < n; i++) begin
            lo = (lo + 32'(lanes[8*i +: 8])) % 32'(ADLER_MOD);
            hi = (hi + lo) % 32'(ADLER_MOD);
        end
        run_low  = lo[HALF_W-1:0];
        run_high = hi[HALF_W-1:0];
        return {run_high, run_low};
    endfunction

    // Offer one item, wait for its transfer, then record the checksum it must produce.
    task automatic send_item(input logic restart, input logic [CNT_W-1:0] count,
                             input logic [31:0] lanes);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, lanes, count};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        checksum_q.push_back(fold_item(restart, count, lanes));
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (checksum_q.size() == 0) begin
                $error("checksum: no result expected, actual %h", m_tdata);
                mismatches++;
            end else begin
                want_sum = checksum_q.pop_front();
                if (m_tdata !== want_sum) begin
                    $error("checksum: expected %h, actual %h", want_sum, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // End the run if nothing transfers for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_reset_state();
        send_item(1'b0, 3'd0, 32'h0000_0000);
        send_item(1'b0, 3'd0, 32'hffff_ffff);
    endtask

    task automatic test_lane_counts();
        send_item(1'b0, 3'd4, 32'hffff_ffff);
        send_item(1'b0, 3'd4, 32'h0000_0000);
        send_item(1'b0, 3'd1, 32'ha5a5_a5ff);
        send_item(1'b0, 3'd2, 32'h5a5a_0180);
        send_item(1'b0, 3'd3, 32'hc37f_00fe);
        send_item(1'b0, 3'd4, 32'h0403_0201);
    endtask

    task automatic test_count_saturation();
        send_item(1'b0, 3'd5, 32'h8040_2010);
        send_item(1'b0, 3'd6, 32'hffff_ffff);
        send_item(1'b0, 3'd7, 32'h7f7f_7f7f);
    endtask

    task automatic test_restart();
        send_item(1'b1, 3'd0, 32'hdead_beef);
        send_item(1'b1, 3'd1, 32'h1234_56ff);
        send_item(1'b0, 3'd4, 32'hffff_ffff);
        send_item(1'b1, 3'd7, 32'hffff_ffff);
        send_item(1'b1, 3'd4, 32'h0000_0000);
        send_item(1'b0, 3'd0, 32'h0000_0000);
    endtask

    // Long runs of 0xff push the low sum past the modulus and the high sum past it many times.
    task automatic test_modulo_wrap();
        send_item(1'b1, 3'd4, 32'hffff_ffff);
        repeat (79) send_item(1'b0, 3'd4, 32'hffff_ffff);
    endtask

    // Hold the output off while items keep coming so the pipeline backs up.
    task automatic test_output_stall();
        hold_req = 1'b1;
        send_item(1'b1, 3'd4, $urandom());
        repeat (29) send_item(1'b0, 3'($urandom_range(4)), $urandom());
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int run_len;
        int fill;
        logic [31:0] lanes;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                fill = $urandom_range(9);
                case (fill)
                    0:       lanes = 32'hffff_ffff;
                    1:       lanes = 32'h0000_0000;
                    default: lanes = $urandom();
                endcase
                if ($urandom_range(9) == 0)
                    send_item(1'($urandom_range(1)), 3'($urandom_range(7)), lanes);
                else if (k == 0)
                    send_item(1'b1, 3'($urandom_range(4)), lanes);
                else
                    send_item(1'b0, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4,
                              lanes);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 9;
        recv_idle = 67;
        test_reset_state();
        test_lane_counts();
        test_count_saturation();
        test_restart();
        test_modulo_wrap();
        test_random_traffic(100);

        send_idle = 67;
        recv_idle = 9;
        test_random_traffic(100);
        test_output_stall();

        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(100);

        s_tvalid <= 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0 && checksum_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
